### hdl/layer_priority_compositor_unit_defines.svh
// Assertion macros for the layer priority compositor.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef LAYER_PRIORITY_COMPOSITOR_UNIT_DEFINES_SVH
`define LAYER_PRIORITY_COMPOSITOR_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define LPC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("lpc check failed");
// next-cycle implication
`define LPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("lpc check failed");
`else
`define LPC_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define LPC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### hdl/lpc_pkg.sv
// Shared types, codes and arithmetic helpers of the layer priority compositor.
// No dependencies; used by all lpc_* modules and the top level.
package lpc_pkg;

	localparam int LAYER_COUNT_DEF = 6;
	localparam int MAX_LAYERS      = 6;
	localparam int LAYER_W         = 40;
	localparam int COLOR_W         = 32;
	localparam int CFG_IDX_W       = 1;
	localparam int CFG_DATA_W      = 2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_BLEND_OP      = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SPRITE_WINDOW = 1'd1;

	// blend modes (code 3 acts as top-alpha)
	localparam logic [1:0] BLEND_TOP    = 2'd0;
	localparam logic [1:0] BLEND_BOTTOM = 2'd1;
	localparam logic [1:0] BLEND_ADD    = 2'd2;

	// shadow kinds
	localparam logic [1:0] SHADOW_NORMAL = 2'd1;
	localparam logic [1:0] SHADOW_MSB    = 2'd2;

	// line screen selects
	localparam logic [1:0] LINE_NONE = 2'd0;
	localparam logic [1:0] LINE_1    = 2'd1;
	localparam logic [1:0] LINE_2    = 2'd2;
	localparam logic [1:0] LINE_3    = 2'd3;

	localparam logic [5:0]         ALPHA_OPAQUE = 6'h3F;
	localparam logic [COLOR_W-1:0] SHADE_PIXEL  = 32'h2000_0000;

	typedef struct packed {
		logic [COLOR_W-1:0] color;
		logic [2:0]         prio;
		logic [1:0]         line;
		logic [1:0]         kind;
		logic               shadow_en;
	} layer_t;

	// what the merge hands to the blend pipeline
	typedef struct packed {
		layer_t             top;
		logic [COLOR_W-1:0] line_color;
		logic [COLOR_W-1:0] bot_color;
		logic               bot_shadow;
	} sel_t;

	function automatic layer_t unpack_layer(input logic [LAYER_W-1:0] w);
		layer_t l;
		l.color     = w[31:0];
		l.prio      = w[34:32];
		l.line      = w[36:35];
		l.kind      = w[38:37];
		l.shadow_en = w[39];
		return l;
	endfunction

	// floor(n / 255), exact for n <= 255*255
	function automatic logic [7:0] div255(input logic [15:0] n);
		logic [16:0] s;
		s = {1'b0, n} + {9'd0, n[15:8]} + 17'd1;
		return s[15:8];
	endfunction

	function automatic logic [7:0] mix_ch(input logic [7:0] t, input logic [7:0] b,
		input logic [7:0] alpha);
		logic [7:0]  ra;
		logic [15:0] pt, pb;
		logic [8:0]  sum;
		ra  = 8'hFF - alpha;
		pt  = {8'd0, t} * {8'd0, alpha};
		pb  = {8'd0, b} * {8'd0, ra};
		sum = {1'b0, div255(pt)} + {1'b0, div255(pb)};
		return sum[7:0];
	endfunction

	function automatic logic is_trans(input logic [COLOR_W-1:0] p, input logic [1:0] mode);
		if (mode == BLEND_BOTTOM || mode == BLEND_ADD)
			return p[31];
		return p[29:24] != ALPHA_OPAQUE;
	endfunction

endpackage

### hdl/lpc_lane.sv
// One priority lane: unpacks its layer word and ranks it against the others.
// Depends on lpc_pkg.
module lpc_lane #(
	parameter int LAYER_COUNT = lpc_pkg::LAYER_COUNT_DEF,
	parameter int LANE        = 0,
	localparam int RANK_W     = (LAYER_COUNT > 2) ? $clog2(LAYER_COUNT) : 1
) (
	input  logic [lpc_pkg::LAYER_W-1:0] layer_word,
	input  logic [2:0]                  prio_all [LAYER_COUNT],
	output lpc_pkg::layer_t             fields,
	output logic                        active,
	output logic [RANK_W-1:0]           rank
);

	assign fields = lpc_pkg::unpack_layer(layer_word);
	assign active = fields.prio != 3'd0;

	// lanes that win over this one: higher priority, or same priority and higher index
	always_comb begin
		rank = '0;
		for (int j = 0; j < LAYER_COUNT; j++) begin
			if (j != LANE && prio_all[j] != 3'd0 &&
				(prio_all[j] > fields.prio || (prio_all[j] == fields.prio && j > LANE)))
				rank = rank + RANK_W'(1);
		end
	end

endmodule

### hdl/lpc_merge.sv
// Merge stage: picks the first and second ranked lanes, fills in the back color.
// Depends on lpc_pkg.
module lpc_merge #(
	parameter int LAYER_COUNT = lpc_pkg::LAYER_COUNT_DEF,
	localparam int RANK_W     = (LAYER_COUNT > 2) ? $clog2(LAYER_COUNT) : 1
) (
	input  lpc_pkg::layer_t              lane_fields [LAYER_COUNT],
	input  logic [LAYER_COUNT-1:0]       lane_active,
	input  logic [RANK_W-1:0]            lane_rank [LAYER_COUNT],
	input  logic [lpc_pkg::COLOR_W-1:0]  back_color,
	input  logic [lpc_pkg::COLOR_W-1:0]  line_color_1,
	input  logic [lpc_pkg::COLOR_W-1:0]  line_color_2,
	input  logic [lpc_pkg::COLOR_W-1:0]  line_color_3,
	output lpc_pkg::sel_t                sel
);

	lpc_pkg::layer_t top_acc, bot_acc;
	logic            top_found, bot_found;

	always_comb begin
		top_acc   = '0;
		bot_acc   = '0;
		top_found = 1'b0;
		bot_found = 1'b0;
		for (int i = 0; i < LAYER_COUNT; i++) begin
			if (lane_active[i] && lane_rank[i] == RANK_W'(0)) begin
				top_acc   = lpc_pkg::layer_t'(top_acc | lane_fields[i]);
				top_found = 1'b1;
			end
			if (lane_active[i] && lane_rank[i] == RANK_W'(1)) begin
				bot_acc   = lpc_pkg::layer_t'(bot_acc | lane_fields[i]);
				bot_found = 1'b1;
			end
		end

		sel.top        = top_acc;
		sel.bot_color  = bot_acc.color;
		sel.bot_shadow = bot_acc.shadow_en;
		if (!top_found) begin
			// nothing on screen: back color on top, empty word below
			sel.top       = '0;
			sel.top.color = back_color;
		end else if (!bot_found) begin
			sel.bot_color  = back_color;
			sel.bot_shadow = 1'b0;
		end

		case (sel.top.line)
			lpc_pkg::LINE_1: sel.line_color = line_color_1;
			lpc_pkg::LINE_2: sel.line_color = line_color_2;
			lpc_pkg::LINE_3: sel.line_color = line_color_3;
			default:         sel.line_color = '0;
		endcase
	end

endmodule

### hdl/lpc_blend.sv
// Color blend unit: top-alpha, bottom-alpha or saturating add of two pixels.
// Depends on lpc_pkg.
module lpc_blend (
	input  logic [lpc_pkg::COLOR_W-1:0] top_color,
	input  logic [lpc_pkg::COLOR_W-1:0] bot_color,
	input  logic [1:0]                  blend_op,
	input  logic                        force_top,
	output logic [lpc_pkg::COLOR_W-1:0] mix_color
);

	logic [7:0]                  alpha;
	logic [5:0]                  out_a;
	logic [7:0]                  mix_r, mix_g, mix_b;
	logic [8:0]                  sum_r, sum_g, sum_b;
	logic [lpc_pkg::COLOR_W-1:0] mixed, added;

	always_comb begin
		if (!force_top && blend_op == lpc_pkg::BLEND_BOTTOM) begin
			alpha = {bot_color[29:24], 2'b11};
			out_a = top_color[29:24];
		end else begin
			alpha = {top_color[29:24], 2'b11};
			out_a = lpc_pkg::ALPHA_OPAQUE;
		end
	end

	assign mix_r = lpc_pkg::mix_ch(top_color[23:16], bot_color[23:16], alpha);
	assign mix_g = lpc_pkg::mix_ch(top_color[15:8], bot_color[15:8], alpha);
	assign mix_b = lpc_pkg::mix_ch(top_color[7:0], bot_color[7:0], alpha);
	assign mixed = {2'b00, out_a, mix_r, mix_g, mix_b};

	assign sum_r = {1'b0, top_color[23:16]} + {1'b0, bot_color[23:16]};
	assign sum_g = {1'b0, top_color[15:8]} + {1'b0, bot_color[15:8]};
	assign sum_b = {1'b0, top_color[7:0]} + {1'b0, bot_color[7:0]};
	assign added = {2'b00, lpc_pkg::ALPHA_OPAQUE,
		sum_r[8] ? 8'hFF : sum_r[7:0],
		sum_g[8] ? 8'hFF : sum_g[7:0],
		sum_b[8] ? 8'hFF : sum_b[7:0]};

	always_comb begin
		if (force_top) begin
			mix_color = mixed;
		end else begin
			case (blend_op)
				lpc_pkg::BLEND_BOTTOM: mix_color = top_color[31] ? mixed : top_color;
				lpc_pkg::BLEND_ADD:    mix_color = added;
				default:               mix_color = mixed;
			endcase
		end
	end

endmodule

### hdl/layer_priority_compositor_unit.sv
// Layer priority compositor, top level. Uses lpc_pkg, lpc_lane, lpc_merge, lpc_blend.
// Each input beat passes, registered, through the select, line blend, rule blend and shade stages.
// Throughput: one beat per cycle when out_ready allows; each of the four stages holds its own valid and
// advances whenever the stage after it is empty or moving, so bubbles fill under stall.
// Reset (arst_n low, asynchronous): stage valids cleared, blend op and
// sprite window registers return to 0.
`include "layer_priority_compositor_unit_defines.svh"
module layer_priority_compositor_unit #(
	parameter int LAYER_COUNT = lpc_pkg::LAYER_COUNT_DEF,
	localparam int RANK_W     = (LAYER_COUNT > 2) ? $clog2(LAYER_COUNT) : 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration write port
	input  logic                          cfg_wr_en,
	input  logic [lpc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [lpc_pkg::CFG_DATA_W-1:0] cfg_data,
	// input channel
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [lpc_pkg::LAYER_W-1:0]   layer_0,
	input  logic [lpc_pkg::LAYER_W-1:0]   layer_1,
	input  logic [lpc_pkg::LAYER_W-1:0]   layer_2,
	input  logic [lpc_pkg::LAYER_W-1:0]   layer_3,
	input  logic [lpc_pkg::LAYER_W-1:0]   layer_4,
	input  logic [lpc_pkg::LAYER_W-1:0]   layer_5,
	input  logic [lpc_pkg::COLOR_W-1:0]   back_color,
	input  logic [lpc_pkg::COLOR_W-1:0]   line_color_1,
	input  logic [lpc_pkg::COLOR_W-1:0]   line_color_2,
	input  logic [lpc_pkg::COLOR_W-1:0]   line_color_3,
	// output channel
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [lpc_pkg::COLOR_W-1:0]   display_color
);

	// ---------------------------------------------------------------
	// configuration registers
	// ---------------------------------------------------------------
	logic [1:0] blend_op_q;
	logic       sprite_window_on_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blend_op_q         <= lpc_pkg::BLEND_TOP;
			sprite_window_on_q <= 1'b0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				lpc_pkg::CFG_BLEND_OP:      blend_op_q         <= cfg_data[1:0];
				lpc_pkg::CFG_SPRITE_WINDOW: sprite_window_on_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------
	// stage flow control: a stage loads when it is empty or its
	// successor takes its beat this cycle
	// ---------------------------------------------------------------
	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic en_s1, en_s2, en_s3, en_s4;

	assign en_s4    = !valid_s4 || out_ready;
	assign en_s3    = !valid_s3 || en_s4;
	assign en_s2    = !valid_s2 || en_s3;
	assign en_s1    = !valid_s1 || en_s2;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (en_s1) valid_s1 <= in_valid;
			if (en_s2) valid_s2 <= valid_s1;
			if (en_s3) valid_s3 <= valid_s2;
			if (en_s4) valid_s4 <= valid_s3;
		end
	end

	// ---------------------------------------------------------------
	// stage 1: priority lanes and merge
	// ---------------------------------------------------------------
	logic [lpc_pkg::LAYER_W-1:0] layer_word [lpc_pkg::MAX_LAYERS];
	lpc_pkg::layer_t             lane_fields [LAYER_COUNT];
	logic [LAYER_COUNT-1:0]      lane_active;
	logic [RANK_W-1:0]           lane_rank [LAYER_COUNT];
	logic [2:0]                  prio_all [LAYER_COUNT];
	lpc_pkg::sel_t               sel;

	assign layer_word[0] = layer_0;
	assign layer_word[1] = layer_1;
	assign layer_word[2] = layer_2;
	assign layer_word[3] = layer_3;
	assign layer_word[4] = layer_4;
	assign layer_word[5] = layer_5;

	// lanes above LAYER_COUNT are not built, so their words drop out
	for (genvar i = 0; i < LAYER_COUNT; i++) begin : g_lane
		assign prio_all[i] = lane_fields[i].prio;

		lpc_lane #(
			.LAYER_COUNT (LAYER_COUNT),
			.LANE        (i)
		) u_lane (
			.layer_word (layer_word[i]),
			.prio_all   (prio_all),
			.fields     (lane_fields[i]),
			.active     (lane_active[i]),
			.rank       (lane_rank[i])
		);
	end

	lpc_merge #(
		.LAYER_COUNT (LAYER_COUNT)
	) u_merge (
		.lane_fields  (lane_fields),
		.lane_active  (lane_active),
		.lane_rank    (lane_rank),
		.back_color   (back_color),
		.line_color_1 (line_color_1),
		.line_color_2 (line_color_2),
		.line_color_3 (line_color_3),
		.sel          (sel)
	);

	logic [lpc_pkg::COLOR_W-1:0] top_color_s1, line_col_s1, bot_color_s1;
	logic [1:0]                  top_line_s1, top_kind_s1;
	logic                        bot_shadow_s1;

	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			top_color_s1  <= sel.top.color;
			top_line_s1   <= sel.top.line;
			top_kind_s1   <= sel.top.kind;
			line_col_s1   <= sel.line_color;
			bot_color_s1  <= sel.bot_color;
			bot_shadow_s1 <= sel.bot_shadow;
		end
	end

	// ---------------------------------------------------------------
	// stage 2: blend top pixel with its line screen color
	// ---------------------------------------------------------------
	logic [lpc_pkg::COLOR_W-1:0] line_mix;
	logic [lpc_pkg::COLOR_W-1:0] res_s2, bot_color_s2;
	logic [1:0]                  kind_s2;
	logic                        bot_shadow_s2;

	lpc_blend u_blend_line (
		.top_color  (top_color_s1),
		.bot_color  (line_col_s1),
		.blend_op   (blend_op_q),
		.force_top  (1'b0),
		.mix_color  (line_mix)
	);

	always_ff @(posedge clk) begin
		if (en_s2 && valid_s1) begin
			res_s2        <= (top_line_s1 != lpc_pkg::LINE_NONE) ? line_mix : top_color_s1;
			kind_s2       <= top_kind_s1;
			bot_color_s2  <= bot_color_s1;
			bot_shadow_s2 <= bot_shadow_s1;
		end
	end

	// ---------------------------------------------------------------
	// stage 3: shadow / translucency rules against the second pixel
	//   - normal shadow, or MSB shadow with black RGB: show the second
	//     pixel, darkened when its shadow enable is set
	//   - otherwise blend over the second pixel when translucent
	//   - MSB shadow with RGB: may be darkened again in stage 4
	// ---------------------------------------------------------------
	logic                        is_msb, rgb_zero, take_bot, do_blend;
	logic [lpc_pkg::COLOR_W-1:0] rule_top, rule_mix;
	logic [lpc_pkg::COLOR_W-1:0] res_s3;
	logic                        shade_s3;

	assign is_msb   = kind_s2 == lpc_pkg::SHADOW_MSB;
	assign rgb_zero = res_s2[23:0] == 24'd0;
	assign take_bot = (kind_s2 == lpc_pkg::SHADOW_NORMAL) || (is_msb && rgb_zero);
	assign rule_top = take_bot ? lpc_pkg::SHADE_PIXEL : res_s2;
	assign do_blend = take_bot ? bot_shadow_s2 : lpc_pkg::is_trans(res_s2, blend_op_q);

	lpc_blend u_blend_rule (
		.top_color  (rule_top),
		.bot_color  (bot_color_s2),
		.blend_op   (blend_op_q),
		.force_top  (take_bot),
		.mix_color  (rule_mix)
	);

	always_ff @(posedge clk) begin
		if (en_s3 && valid_s2) begin
			res_s3   <= do_blend ? rule_mix : (take_bot ? bot_color_s2 : res_s2);
			shade_s3 <= is_msb && !rgb_zero && !sprite_window_on_q;
		end
	end

	// ---------------------------------------------------------------
	// stage 4: sprite self-shadow darkening, alpha expand, output beat
	// ---------------------------------------------------------------
	logic [lpc_pkg::COLOR_W-1:0] shade_mix, final_px;
	logic [lpc_pkg::COLOR_W-1:0] display_color_s4;

	lpc_blend u_blend_shade (
		.top_color  (lpc_pkg::SHADE_PIXEL),
		.bot_color  (res_s3),
		.blend_op   (blend_op_q),
		.force_top  (1'b1),
		.mix_color  (shade_mix)
	);

	assign final_px = shade_s3 ? shade_mix : res_s3;

	always_ff @(posedge clk) begin
		if (en_s4 && valid_s3) begin
			// 6-bit alpha to 8 bits as (a << 2) + 3; an all-zero pixel stays zero
			display_color_s4 <= (final_px == '0) ? '0 :
				{final_px[29:24], 2'b11, final_px[23:0]};
		end
	end

	assign out_valid     = valid_s4;
	assign display_color = display_color_s4;

	// ---------------------------------------------------------------
	// checks
	// ---------------------------------------------------------------
	`LPC_ASSERT_NOW(a_stall_blocks_input, clk, arst_n, valid_s1 && !en_s2, !in_ready)
	`LPC_ASSERT_NEXT(a_accept_fills_s1, clk, arst_n, in_valid && in_ready, valid_s1)
	`LPC_ASSERT_NEXT(a_s3_moves_to_out, clk, arst_n, valid_s3 && en_s4, out_valid)
	`LPC_ASSERT_NOW(a_alpha_expanded, clk, arst_n, out_valid,
		display_color == 32'd0 || display_color[25:24] == 2'b11)

endmodule
